@@ rtl/sst_pkg.sv @@
// Shared types, constants and helper functions for the test-signal synthesizer.
package sst_pkg;

    localparam int SAMPLE_W  = 12;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;
    localparam int SUM_W     = 45;
    localparam int Q30_SHIFT = 30;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRETRIGGER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AMP_SINE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AMP_SQUARE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY       = 3'd4;

    localparam logic [15:0] DUTY_RESET = 16'd32768;

    localparam logic [31:0] LCG_MUL  = 32'd1103515245;
    localparam logic [31:0] LCG_ADD  = 32'd12345;
    localparam logic [31:0] LCG_SEED = 32'hA5A5F00D;

    localparam logic signed [9:0]  JITTER_GAIN = 10'sd417;
    localparam logic signed [13:0] HARM3_Q15   = 14'sd5898;
    localparam logic signed [12:0] HARM5_Q15   = 13'sd2294;
    localparam logic signed [12:0] CH1_OFFSET  = 13'sd2048;
    localparam logic signed [12:0] CH2_OFFSET  = 13'sd1348;
    localparam logic signed [3:0]  CH1_NOISE   = 4'sd6;
    localparam logic signed [3:0]  CH2_NOISE   = 4'sd5;
    localparam logic [SAMPLE_W-1:0] FULL_SCALE = 12'd4095;

    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
    localparam logic [31:0] HALF_Q30    = 32'h2000_0000;
    localparam logic [31:0] Q15_MAX     = 32'd32767;

    typedef struct packed {
        logic [31:0] phase_step;
        logic [11:0] pretrigger;
        logic [10:0] amp_sine;
        logic [10:0] amp_square;
        logic [15:0] duty;
    } cfg_t;

    typedef enum logic [3:0] {
        E_IDLE,
        E_JIT,
        E_PHASE,
        E_ADD,
        E_RD1,
        E_RD3,
        E_RD5,
        E_ACC,
        E_AMP,
        E_SUM,
        E_DONE
    } eng_state_t;

    typedef enum logic [3:0] {
        F_START,
        F_Y,
        F_Y2,
        F_DIV,
        F_MT,
        F_S,
        F_Q,
        F_WR,
        F_DONE
    } fill_state_t;

    // series divisors 72, 42, 20, 6 (innermost first) as pre-shift, reciprocal, post-shift
    function automatic logic [1:0] div_pre(input logic [1:0] stage);
        logic [1:0] p;
        case (stage)
            2'd0:    p = 2'd3;
            2'd1:    p = 2'd1;
            2'd2:    p = 2'd2;
            default: p = 2'd1;
        endcase
        return p;
    endfunction

    function automatic logic [31:0] div_mul(input logic [1:0] stage);
        logic [31:0] m;
        case (stage)
            2'd0:    m = 32'd954437177;
            2'd1:    m = 32'd3272356036;
            2'd2:    m = 32'd1717986919;
            default: m = 32'd2863311531;
        endcase
        return m;
    endfunction

    function automatic logic [5:0] div_post(input logic [1:0] stage);
        logic [5:0] s;
        case (stage)
            2'd0:    s = 6'd33;
            2'd1:    s = 6'd36;
            2'd2:    s = 6'd33;
            default: s = 6'd33;
        endcase
        return s;
    endfunction

    // upper LCG half minus 32768
    function automatic logic signed [15:0] noise_of(input logic [31:0] lcg);
        return $signed({~lcg[31], lcg[30:16]});
    endfunction

    // Q30 sum to saturated 12-bit code
    function automatic logic [SAMPLE_W-1:0] to_sample(input logic signed [SUM_W-1:0] s);
        logic [SAMPLE_W-1:0] v;
        if (s[SUM_W-1])
        begin
            v = '0;
        end
        else if (|s[SUM_W-2:Q30_SHIFT+SAMPLE_W])
        begin
            v = FULL_SCALE;
        end
        else
        begin
            v = s[Q30_SHIFT+SAMPLE_W-1:Q30_SHIFT];
        end
        return v;
    endfunction

endpackage

@@ rtl/sst_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module sst_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/sst_rom_fill.sv @@
// Sine table builder: evaluates the quarter-wave polynomial per entry and writes the RAM.
module sst_rom_fill #(
    parameter int TABLE_ENTRIES = 4096
) (
    input  logic                             clk,
    input  logic                             rst_n,
    output logic                             tbl_we,
    output logic [$clog2(TABLE_ENTRIES)-1:0] tbl_waddr,
    output logic [15:0]                      tbl_wdata,
    output logic                             fill_done
);

    import sst_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_ENTRIES);

    fill_state_t state_reg, state_next;

    logic [ADDR_W-1:0]    entry_reg;
    logic [1:0]           stage_reg;
    logic [1:0]           quad_reg;
    logic [30:0]          r_reg;
    logic [30:0]          y_reg;
    logic [31:0]          y2_reg;
    logic [31:0]          x_reg;
    logic [30:0]          t_reg;
    logic [30:0]          s_reg;
    logic [15:0]          wdata_reg;

    logic [31:0] turns;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [33:0] prod_hi;
    logic [63:0] q_round;
    logic [16:0] q_full;
    logic [14:0] q_sat;
    logic [30:0] div_quo;
    logic        last_entry;

    assign turns      = 32'(entry_reg) << (32 - ADDR_W);
    assign last_entry = (entry_reg == ADDR_W'(TABLE_ENTRIES - 1));

    always_comb
    begin
        case (state_reg)
            F_Y:
            begin
                mul_a = {1'b0, r_reg};
                mul_b = HALF_PI_Q30;
            end
            F_Y2:
            begin
                mul_a = {1'b0, y_reg};
                mul_b = {1'b0, y_reg};
            end
            F_DIV:
            begin
                mul_a = x_reg >> div_pre(stage_reg);
                mul_b = div_mul(stage_reg);
            end
            F_MT:
            begin
                mul_a = y2_reg;
                mul_b = {1'b0, t_reg};
            end
            F_S:
            begin
                mul_a = {1'b0, y_reg};
                mul_b = {1'b0, t_reg};
            end
            F_Q:
            begin
                mul_a = {1'b0, s_reg};
                mul_b = Q15_MAX;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod    = mul_a * mul_b;
    assign prod_hi = prod[63:30];
    assign q_round = prod + 64'(HALF_Q30);
    assign q_full  = q_round[46:30];
    assign q_sat   = (q_full > 17'(Q15_MAX)) ? 15'(Q15_MAX) : q_full[14:0];

    // division by a series constant through its reciprocal
    assign div_quo = 31'(prod >> div_post(stage_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_START;
            entry_reg <= '0;
            stage_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                F_START:
                begin
                    stage_reg <= '0;
                end
                F_DIV:
                begin
                    stage_reg <= stage_reg + 1'b1;
                end
                F_WR:
                begin
                    if (!last_entry)
                    begin
                        entry_reg <= entry_reg + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            F_START:
            begin
                quad_reg <= turns[31:30];
                r_reg    <= turns[30] ? ONE_Q30 - {1'b0, turns[29:0]} : {1'b0, turns[29:0]};
            end
            F_Y:
            begin
                y_reg <= prod_hi[30:0];
            end
            F_Y2:
            begin
                y2_reg <= prod_hi[31:0];
                x_reg  <= prod_hi[31:0];
            end
            F_DIV:
            begin
                t_reg <= ONE_Q30 - div_quo;
            end
            F_MT:
            begin
                x_reg <= prod_hi[31:0];
            end
            F_S:
            begin
                s_reg <= prod_hi[30:0];
            end
            F_Q:
            begin
                wdata_reg <= quad_reg[1] ? 16'(-$signed({1'b0, q_sat})) : {1'b0, q_sat};
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_START: state_next = F_Y;
            F_Y:     state_next = F_Y2;
            F_Y2:    state_next = F_DIV;
            F_DIV:   state_next = (stage_reg == 2'd3) ? F_S : F_MT;
            F_MT:    state_next = F_DIV;
            F_S:     state_next = F_Q;
            F_Q:     state_next = F_WR;
            F_WR:    state_next = last_entry ? F_DONE : F_START;
            F_DONE:  state_next = F_DONE;
            default: state_next = F_START;
        endcase
    end

    assign tbl_we    = (state_reg == F_WR);
    assign tbl_waddr = entry_reg;
    assign tbl_wdata = wdata_reg;
    assign fill_done = (state_reg == F_DONE);

endmodule

@@ rtl/sst_engine.sv @@
// Per-sample sequencer: LCG, phase, three table reads, channel sums and output register.
module sst_engine #(
    parameter int TABLE_ENTRIES = 4096
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  sst_pkg::cfg_t                    cfg,
    input  logic                             fill_done,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [11:0]                      sample_index,
    input  logic                             first_of_frame,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [11:0]                      ch1_sample,
    output logic [11:0]                      ch2_sample,
    output logic [$clog2(TABLE_ENTRIES)-1:0] rd_addr,
    input  logic [15:0]                      rd_data
);

    import sst_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_ENTRIES);

    eng_state_t state_reg, state_next;

    logic [31:0]          lcg_reg;
    logic [31:0]          jitter_reg;
    logic [11:0]          idx_reg;
    logic                 first_reg;
    logic [31:0]          prod_reg;
    logic [31:0]          phase_reg;
    logic [ADDR_W-1:0]    p3_reg, p5_reg;
    logic signed [15:0]   n1_reg, n2_reg;
    logic signed [15:0]   t1_reg, t3_reg;
    logic signed [31:0]   acc_reg;
    logic signed [43:0]   mprod_reg;
    logic [SAMPLE_W-1:0]  res1_reg, res2_reg;
    logic                 out_valid_reg;
    logic [SAMPLE_W-1:0]  ch1_reg, ch2_reg;

    logic [31:0]          lcg_step;
    logic signed [25:0]   jit_prod;
    logic signed [12:0]   diff13;
    logic [31:0]          diff32;
    logic [31:0]          p3_full, p5_full;
    logic signed [15:0]   t5_s;
    logic signed [31:0]   acc_sum;
    logic signed [19:0]   nz1, nz2;
    logic                 sq_high;
    logic signed [12:0]   lvl2;
    logic signed [SUM_W-1:0] sum1, sum2;
    logic                 accept;
    logic                 push;

    assign lcg_step = 32'(lcg_reg * LCG_MUL) + LCG_ADD;
    assign jit_prod = noise_of(lcg_reg) * JITTER_GAIN;

    assign diff13 = $signed({1'b0, idx_reg}) - $signed({1'b0, cfg.pretrigger});
    assign diff32 = {{19{diff13[12]}}, diff13};

    assign p3_full = phase_reg + {phase_reg[30:0], 1'b0};
    assign p5_full = phase_reg + {phase_reg[29:0], 2'b0};

    assign t5_s    = $signed(rd_data);
    assign acc_sum = (32'(t1_reg) <<< 15) + 32'(HARM3_Q15) * 32'(t3_reg)
                   + 32'(HARM5_Q15) * 32'(t5_s);

    assign nz1     = n1_reg * CH1_NOISE;
    assign nz2     = n2_reg * CH2_NOISE;
    assign sq_high = (phase_reg < {cfg.duty, 16'b0});
    assign lvl2    = sq_high ? CH2_OFFSET + $signed({2'b0, cfg.amp_square})
                             : CH2_OFFSET - $signed({2'b0, cfg.amp_square});

    assign sum1 = (SUM_W'(CH1_OFFSET) <<< Q30_SHIFT) + SUM_W'(mprod_reg) + (SUM_W'(nz1) <<< 15);
    assign sum2 = (SUM_W'(lvl2) <<< Q30_SHIFT) + (SUM_W'(nz2) <<< 15);

    assign in_ready = (state_reg == E_IDLE) && fill_done;
    assign accept   = in_valid && in_ready;
    assign push     = (state_reg == E_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        case (state_reg)
            E_RD3:   rd_addr = p3_reg;
            E_RD5:   rd_addr = p5_reg;
            default: rd_addr = phase_reg[31 -: ADDR_W];
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            E_IDLE:
            begin
                if (accept)
                begin
                    state_next = first_of_frame ? E_JIT : E_PHASE;
                end
            end
            E_JIT:   state_next = E_PHASE;
            E_PHASE: state_next = E_ADD;
            E_ADD:   state_next = E_RD1;
            E_RD1:   state_next = E_RD3;
            E_RD3:   state_next = E_RD5;
            E_RD5:   state_next = E_ACC;
            E_ACC:   state_next = E_AMP;
            E_AMP:   state_next = E_SUM;
            E_SUM:   state_next = E_DONE;
            E_DONE:
            begin
                if (push)
                begin
                    state_next = E_IDLE;
                end
            end
            default: state_next = E_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= E_IDLE;
            lcg_reg       <= LCG_SEED;
            jitter_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                E_JIT, E_RD1, E_RD3:
                begin
                    lcg_reg <= lcg_step;
                end
                E_PHASE:
                begin
                    if (first_reg)
                    begin
                        jitter_reg <= {{6{jit_prod[25]}}, jit_prod};
                    end
                end
                default:
                begin
                end
            endcase
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            E_IDLE:
            begin
                idx_reg   <= sample_index;
                first_reg <= first_of_frame;
            end
            E_PHASE:
            begin
                prod_reg <= 32'(cfg.phase_step * diff32);
            end
            E_ADD:
            begin
                phase_reg <= prod_reg + jitter_reg;
            end
            E_RD1:
            begin
                p3_reg <= p3_full[31 -: ADDR_W];
                p5_reg <= p5_full[31 -: ADDR_W];
                n1_reg <= noise_of(lcg_step);
            end
            E_RD3:
            begin
                t1_reg <= $signed(rd_data);
                n2_reg <= noise_of(lcg_step);
            end
            E_RD5:
            begin
                t3_reg <= $signed(rd_data);
            end
            E_ACC:
            begin
                acc_reg <= acc_sum;
            end
            E_AMP:
            begin
                mprod_reg <= $signed({1'b0, cfg.amp_sine}) * acc_reg;
            end
            E_SUM:
            begin
                res1_reg <= to_sample(sum1);
                res2_reg <= to_sample(sum2);
            end
            default:
            begin
            end
        endcase
        if (push)
        begin
            ch1_reg <= res1_reg;
            ch2_reg <= res2_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign ch1_sample = ch1_reg;
    assign ch2_sample = ch2_reg;

endmodule

@@ rtl/scope_test_signal_synth.sv @@
// A transaction is accepted only while the engine is idle, so samples are processed one at a
// time; the sequence is set by the three reads through the single read port of the sine
// table RAM and the shared LCG multiplier, with an extra jitter draw on a frame's first sample.
// Reset: config and LCG return to defaults; the sine table is rebuilt from the polynomial,
// during which in_ready stays low and config writes still land.
// The output register holds one finished sample so a new transaction can start meanwhile.
module scope_test_signal_synth #(
    parameter int TABLE_ENTRIES = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [11:0]                   sample_index,
    input  logic                          first_of_frame,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [11:0]                   ch1_sample,
    output logic [11:0]                   ch2_sample,
    input  logic                          cfg_we,
    input  logic [sst_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sst_pkg::CFG_DAT_W-1:0] cfg_data
);

    import sst_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_ENTRIES);

    cfg_t cfg_reg;

    logic              tbl_we;
    logic [ADDR_W-1:0] tbl_waddr;
    logic [15:0]       tbl_wdata;
    logic              fill_done;
    logic [ADDR_W-1:0] tbl_raddr;
    logic [15:0]       tbl_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_step <= '0;
            cfg_reg.pretrigger <= '0;
            cfg_reg.amp_sine   <= '0;
            cfg_reg.amp_square <= '0;
            cfg_reg.duty       <= DUTY_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PHASE_STEP: cfg_reg.phase_step <= cfg_data;
                CFG_PRETRIGGER: cfg_reg.pretrigger <= cfg_data[11:0];
                CFG_AMP_SINE:   cfg_reg.amp_sine   <= cfg_data[10:0];
                CFG_AMP_SQUARE: cfg_reg.amp_square <= cfg_data[10:0];
                CFG_DUTY:       cfg_reg.duty       <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    sst_rom_fill #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_fill (
        .clk      (clk),
        .rst_n    (rst_n),
        .tbl_we   (tbl_we),
        .tbl_waddr(tbl_waddr),
        .tbl_wdata(tbl_wdata),
        .fill_done(fill_done)
    );

    sst_ram #(
        .WIDTH(16),
        .DEPTH(TABLE_ENTRIES)
    ) u_table (
        .clk    (clk),
        .wr_en  (tbl_we),
        .wr_addr(tbl_waddr),
        .wr_data(tbl_wdata),
        .rd_addr(tbl_raddr),
        .rd_data(tbl_rdata)
    );

    sst_engine #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .fill_done     (fill_done),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample_index  (sample_index),
        .first_of_frame(first_of_frame),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .ch1_sample    (ch1_sample),
        .ch2_sample    (ch2_sample),
        .rd_addr       (tbl_raddr),
        .rd_data       (tbl_rdata)
    );

`ifndef SYNTHESIS
    a_no_write_after_fill: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_we |-> !fill_done)
        else $error("table write after fill finished");

    a_accept_needs_table: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> fill_done)
        else $error("transaction accepted before table is built");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("engine accepted while busy");

    a_fill_ends_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(fill_done) |-> $past(tbl_we))
        else $error("fill finished without a final write");
`endif

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the two-channel test-signal synthesizer.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sst_pkg::*;

    localparam int     TABLE_N       = 4096;
    localparam longint UNIT_Q30      = 64'sd1073741824;
    localparam longint QTR_TURN_RAD  = 64'sd1686629713;
    localparam longint CODE_MAX      = 64'sd4095;
    localparam longint JIT_GAIN      = 64'sd417;
    localparam longint H3_GAIN       = 64'sd5898;
    localparam longint H5_GAIN       = 64'sd2294;
    localparam longint CH1_MID       = 64'sd2048;
    localparam longint CH2_MID       = 64'sd1348;
    localparam longint CH1_NOISE_AMP = 64'sd6;
    localparam longint CH2_NOISE_AMP = 64'sd5;
    localparam logic [31:0] RNG_MUL  = 32'd1103515245;
    localparam logic [31:0] RNG_INC  = 32'd12345;
    localparam logic [31:0] RNG_SEED = 32'hA5A5F00D;
    localparam logic [15:0] DUTY_AT_RESET = 16'h8000;

    localparam int  RANDOM_PHASES   = 8;
    localparam int  ITEMS_PER_PHASE = 130;
    localparam int  HOLD_CYCLES     = 300;
    localparam int  DRAIN_CYCLES    = 24;
    localparam longint CYCLE_LIMIT  = 1000000;

    typedef struct {
        logic [11:0] index;
        logic        first;
    } sample_request_t;

    typedef struct {
        logic [11:0] ch1;
        logic [11:0] ch2;
    } sample_pair_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [11:0]          sample_index = '0;
    logic                 first_of_frame = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [11:0]          ch1_sample;
    logic [11:0]          ch2_sample;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    scope_test_signal_synth dut (.*);

    always #5 clk = ~clk;

    // predictor state
    shortint     sine_rom [TABLE_N];
    logic [31:0] rng_state;
    logic [31:0] frame_jitter;
    logic [31:0] m_step;
    logic [11:0] m_pretrig;
    longint      m_amp_sine;
    longint      m_amp_square;
    logic [15:0] m_duty;

    sample_request_t sample_requests[$];
    sample_pair_t    predicted_samples[$];

    int     errors = 0;
    int     sent_count = 0;
    int     frame_starts = 0;
    int     clipped_codes = 0;
    int     settings_count = 0;
    int     send_gap = 0;
    int     stall_left = 0;
    int     hold_left = 0;
    int     hold_reqs = 0;
    int     hold_seen = 0;
    int     send_idle_pct = 10;
    int     recv_idle_pct = 10;
    bit     quiet = 1'b0;
    longint cycle_count = 0;

    function automatic shortint sine_entry(input logic [31:0] turns);
        longint unsigned r, y, y2, t, s, q;
        r = 64'(turns[29:0]);
        if (turns[30])
        begin
            r = UNIT_Q30 - r;
        end
        y  = (r * QTR_TURN_RAD) >> 30;
        y2 = (y * y) >> 30;
        t  = UNIT_Q30 - y2 / 72;
        t  = UNIT_Q30 - ((y2 * t) >> 30) / 42;
        t  = UNIT_Q30 - ((y2 * t) >> 30) / 20;
        t  = UNIT_Q30 - ((y2 * t) >> 30) / 6;
        s  = (y * t) >> 30;
        q  = (s * 32767 + (UNIT_Q30 >> 1)) >> 30;
        if (q > 32767)
        begin
            q = 32767;
        end
        return turns[31] ? -shortint'(q) : shortint'(q);
    endfunction

    function automatic longint rng_draw();
        rng_state = rng_state * RNG_MUL + RNG_INC;
        return longint'(rng_state[31:16]) - 32768;
    endfunction

    function automatic longint rom_at(input logic [31:0] turns);
        return longint'(sine_rom[(64'(turns) * TABLE_N) >> 32]);
    endfunction

    function automatic logic [11:0] to_code(input longint total);
        longint v;
        if (total < 0)
        begin
            clipped_codes++;
            return '0;
        end
        v = total >>> 30;
        if (v > CODE_MAX)
        begin
            clipped_codes++;
            return 12'(CODE_MAX);
        end
        return 12'(v);
    endfunction

    function automatic sample_pair_t synth_sample(input logic [11:0] index, input logic first);
        sample_pair_t r;
        logic [31:0]  offset;
        logic [31:0]  phase;
        longint       draw;
        longint       harmonics;
        longint       sq;
        if (first)
        begin
            draw = rng_draw();
            frame_jitter = 32'(draw * JIT_GAIN);
            frame_starts++;
        end
        offset = 32'(index) - 32'(m_pretrig);
        phase  = m_step * offset + frame_jitter;
        harmonics = rom_at(phase) * 32768 + H3_GAIN * rom_at(phase * 32'd3)
                  + H5_GAIN * rom_at(phase * 32'd5);
        r.ch1 = to_code(CH1_MID * UNIT_Q30 + m_amp_sine * harmonics
                        + CH1_NOISE_AMP * rng_draw() * 32768);
        sq = (phase < {m_duty, 16'h0}) ? m_amp_square : -m_amp_square;
        r.ch2 = to_code((CH2_MID + sq) * UNIT_Q30 + CH2_NOISE_AMP * rng_draw() * 32768);
        return r;
    endfunction

    function automatic void model_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        case (idx)
            CFG_PHASE_STEP: m_step = data;
            CFG_PRETRIGGER: m_pretrig = data[11:0];
            CFG_AMP_SINE:   m_amp_sine = longint'(data[10:0]);
            CFG_AMP_SQUARE: m_amp_square = longint'(data[10:0]);
            CFG_DUTY:       m_duty = data[15:0];
            default:        ;
        endcase
    endfunction

    function automatic logic [31:0] pick_setting(input logic [31:0] top);
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0:       v = '0;
            1:       v = top;
            2:       v = $urandom & (top >> 6);
            default: v = $urandom & top;
        endcase
        return v;
    endfunction

    // upper bits above the register width are filled with junk
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value,
                             input int width);
        logic [31:0] data;
        data = (width >= 32) ? value : ((32'($urandom) << width) | value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        model_write(idx, data);
    endtask

    task automatic set_config(input logic [31:0] step, input logic [11:0] pretrig,
                              input logic [10:0] asine, input logic [10:0] asquare,
                              input logic [15:0] duty);
        write_reg(CFG_PHASE_STEP, step, 32);
        write_reg(CFG_PRETRIGGER, 32'(pretrig), 12);
        write_reg(CFG_AMP_SINE, 32'(asine), 11);
        write_reg(CFG_AMP_SQUARE, 32'(asquare), 11);
        write_reg(CFG_DUTY, 32'(duty), 16);
        write_reg(CFG_DUTY + CFG_IDX_W'($urandom_range(1, 3)), $urandom, 32);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        settings_count++;
    endtask

    task automatic queue_item(input logic [11:0] index, input logic first);
        sample_request_t req;
        req.index = index;
        req.first = first;
        sample_requests.push_back(req);
    endtask

    // mostly runs of consecutive indexes opened by a frame start, some stray items
    task automatic queue_frames(input int count);
        int          made;
        int          len;
        logic [11:0] start;
        made = 0;
        while (made < count)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                queue_item(12'($urandom), 1'($urandom));
                made++;
            end
            else
            begin
                len   = $urandom_range(4, 40);
                start = 12'($urandom);
                for (int j = 0; j < len && made < count; j++)
                begin
                    queue_item(start + 12'(j), j == 0);
                    made++;
                end
            end
        end
    endtask

    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (sample_requests.size() != 0 || in_valid || predicted_samples.size() != 0);
    endtask

    task automatic report_field(input string name, input logic [11:0] want, input logic [11:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive
        sample_request_t req;
        if (!rst_n)
        begin
            in_valid       <= 1'b0;
            sample_index   <= '0;
            first_of_frame <= 1'b0;
            send_gap       <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predicted_samples.push_back(synth_sample(sample_index, first_of_frame));
                sent_count++;
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (sample_requests.size() != 0 && !quiet
                         && $urandom_range(0, 99) < send_idle_pct)
                begin
                    send_gap <= $urandom_range(0, 15);
                    in_valid <= 1'b0;
                end
                else if (sample_requests.size() != 0)
                begin
                    req = sample_requests.pop_front();
                    in_valid       <= 1'b1;
                    sample_index   <= req.index;
                    first_of_frame <= req.first;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : watch
        sample_pair_t want;
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
            hold_left  <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (predicted_samples.size() == 0)
                begin
                    errors++;
                    $display("%0t unexpected transaction: expected none, actual ch1 %0d ch2 %0d",
                             $time, ch1_sample, ch2_sample);
                end
                else
                begin
                    want = predicted_samples.pop_front();
                    report_field("ch1_sample", want.ch1, ch1_sample);
                    report_field("ch2_sample", want.ch2, ch2_sample);
                end
            end
            if (hold_seen != hold_reqs)
            begin
                hold_seen <= hold_reqs;
                hold_left <= HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_ready  <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 99) < recv_idle_pct)
            begin
                stall_left <= $urandom_range(0, 15);
                out_ready  <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d transactions still expected",
                 cycle_count, predicted_samples.size());
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        int idle_levels[4];
        idle_levels = '{0, 8, 25, 60};
        for (int i = 0; i < TABLE_N; i++)
        begin
            sine_rom[i] = sine_entry(32'((longint'(i) << 32) / TABLE_N));
        end
        rng_state    = RNG_SEED;
        frame_jitter = '0;
        m_step       = '0;
        m_pretrig    = '0;
        m_amp_sine   = 0;
        m_amp_square = 0;
        m_duty       = DUTY_AT_RESET;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset defaults: flat channels at their offsets
        queue_item(12'd0, 1'b1);
        queue_item(12'd4095, 1'b0);
        wait_drained();

        // full amplitude, near-full duty, indexes around the origin
        set_config(32'h0400_0000, 12'd100, 11'd2047, 11'd2047, 16'hFFFF);
        queue_item(12'd0, 1'b1);
        queue_item(12'd4095, 1'b0);
        queue_item(12'd99, 1'b0);
        queue_item(12'd100, 1'b0);
        queue_item(12'd101, 1'b1);
        queue_item(12'd2048, 1'b0);
        queue_item(12'd1, 1'b0);
        queue_item(12'd4094, 1'b1);
        wait_drained();

        // maximum step, zero amplitude, zero duty
        set_config(32'hFFFF_FFFF, 12'd4095, 11'd0, 11'd0, 16'd0);
        queue_item(12'd4095, 1'b0);
        queue_item(12'd0, 1'b1);
        queue_item(12'd2047, 1'b0);
        queue_item(12'd4094, 1'b0);
        wait_drained();

        // zero step: phase is the jitter alone, straddling zero and the duty edge
        set_config(32'd0, 12'd0, 11'd1024, 11'd1000, 16'h8000);
        queue_item(12'd0, 1'b1);
        queue_item(12'd0, 1'b0);
        queue_item(12'd4095, 1'b1);
        queue_item(12'd1, 1'b0);
        queue_item(12'd2730, 1'b1);
        wait_drained();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            set_config(pick_setting(32'hFFFF_FFFF), 12'(pick_setting(32'hFFF)),
                       11'(pick_setting(32'h7FF)), 11'(pick_setting(32'h7FF)),
                       16'(pick_setting(32'hFFFF)));
            quiet         = (p == RANDOM_PHASES - 1);
            send_idle_pct = idle_levels[(p + 1) % 4];
            recv_idle_pct = idle_levels[(p + 3) % 4];
            queue_frames(ITEMS_PER_PHASE);
            if (p == 2)
            begin
                hold_reqs++;
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Sent %0d transactions over %0d register settings, %0d frame starts.",
                 sent_count, settings_count, frame_starts);
        $display("Codes clipped: %0d; one %0d-cycle output hold-off; last phase without idling.",
                 clipped_codes, HOLD_CYCLES);
        if (errors == 0 && predicted_samples.size() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
